/* hw/rtl/ntkd_pkg.sv */
// Shared types, command codes and default sizes for the node table.
package ntkd_pkg;

    localparam int NODES_DEF    = 16;
    localparam int ID_BYTES_DEF = 8;

    localparam int CMD_W   = 3;
    localparam int DEV_W   = 64;
    localparam int ADDR_W  = 16;
    localparam int SESS_W  = 32;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int SEQ_W   = 8;
    localparam int COUNT_W = 5;
    localparam int COUNT_MAX = 31;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_REGISTER  = 3'd0;
    localparam t_cmd CMD_FIND_ADDR = 3'd1;
    localparam t_cmd CMD_FIND_DEV  = 3'd2;
    localparam t_cmd CMD_REMOVE    = 3'd3;
    localparam t_cmd CMD_EXPIRE    = 3'd4;
    localparam t_cmd CMD_REFRESH   = 3'd5;
    localparam t_cmd CMD_CHECK_SEQ = 3'd6;
    localparam t_cmd CMD_RECORD    = 3'd7;

    typedef struct packed {
        t_cmd              cmd;
        logic [DEV_W-1:0]  device_id;
        logic [ADDR_W-1:0] node_address;
        logic [SESS_W-1:0] session;
        logic [TIME_W-1:0] now_ms;
        logic [SLOT_W-1:0] slot;
        logic [SEQ_W-1:0]  seq_number;
    } t_item;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  hit_slot;
        logic [ADDR_W-1:0]  entry_address;
        logic [SESS_W-1:0]  entry_session;
        logic [DEV_W-1:0]   entry_device;
        logic               duplicate;
        logic [COUNT_W-1:0] removed_count;
    } t_result;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic match;
        logic select;
        logic commit;
    } t_dp_ctrl;

endpackage

/* hw/rtl/ntkd_ctrl.sv */
// Command sequencer: steps each command through match, select and commit.
module ntkd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_done,
    output ntkd_pkg::t_dp_ctrl  o_ctrl
);
    import ntkd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MATCH  = 2'd1;
    localparam logic [1:0] S_SELECT = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_MATCH;
            S_MATCH:  n_state = S_SELECT;
            S_SELECT: n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_COMMIT);
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_ctrl.load   = (r_state == S_IDLE) && start;
    assign o_ctrl.match  = (r_state == S_MATCH);
    assign o_ctrl.select = (r_state == S_SELECT);
    assign o_ctrl.commit = (r_state == S_COMMIT);

endmodule

/* hw/rtl/ntkd_dp.sv */
// Node table storage with parallel match, priority select and write-back.
module ntkd_dp #(
    parameter int NODES    = ntkd_pkg::NODES_DEF,
    parameter int ID_BYTES = ntkd_pkg::ID_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ntkd_pkg::t_dp_ctrl                  i_ctrl,
    input  ntkd_pkg::t_item                     i_item,
    input  logic                                i_cfg_we,
    input  logic [ntkd_pkg::TIME_W-1:0]         i_cfg_data,
    output ntkd_pkg::t_result                   o_result
);
    import ntkd_pkg::*;

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [DEV_W-1:0] ID_MASK = (ID_BYTES >= 8) ? {DEV_W{1'b1}} :
        ((64'd1 << (8 * ID_BYTES)) - 64'd1);

    logic [TIME_W-1:0] r_timeout;
    t_item             r_item;
    t_item             load_item;

    logic              r_valid [NODES];
    logic [DEV_W-1:0]  r_dev   [NODES];
    logic [ADDR_W-1:0] r_addr  [NODES];
    logic [SESS_W-1:0] r_sess  [NODES];
    logic [TIME_W-1:0] r_dl    [NODES];
    logic [SEQ_W-1:0]  r_seq   [NODES];
    logic              r_known [NODES];

    logic [NODES-1:0]  r_dev_hit;
    logic [NODES-1:0]  r_addr_hit;
    logic [NODES-1:0]  r_free;
    logic [NODES-1:0]  r_expired;
    logic [TIME_W-1:0] r_new_dl;

    logic              r_found;
    logic [IDX_W-1:0]  r_idx;
    logic [COUNT_W-1:0] r_count;
    t_result           r_result;
    t_result           n_result;

    logic              slot_ok;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  first_dev;
    logic [IDX_W-1:0]  first_addr;
    logic [IDX_W-1:0]  first_free;
    int                n_expired;

    assign slot_ok  = (int'(r_item.slot) < NODES);
    assign slot_idx = IDX_W'(r_item.slot);

    // Only the low ID_BYTES bytes of the device id take part in matching.
    always_comb begin
        load_item           = i_item;
        load_item.device_id = i_item.device_id & ID_MASK;
    end

    // Lowest set bit wins: scan from the top so the last write is the lowest.
    always_comb begin
        first_dev  = '0;
        first_addr = '0;
        first_free = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (r_dev_hit[i])  first_dev  = IDX_W'(i);
            if (r_addr_hit[i]) first_addr = IDX_W'(i);
            if (r_free[i])     first_free = IDX_W'(i);
        end
    end

    assign n_expired = $countones(r_expired);

    always_comb begin
        n_result = '0;
        case (r_item.cmd)
            CMD_REGISTER: begin
                if (r_found) begin
                    n_result.hit           = 1'b1;
                    n_result.hit_slot      = SLOT_W'(r_idx);
                    n_result.entry_address = r_item.node_address;
                    n_result.entry_session = r_item.session;
                    n_result.entry_device  = r_item.device_id;
                end
            end
            CMD_FIND_ADDR, CMD_FIND_DEV: begin
                if (r_found) begin
                    n_result.hit           = 1'b1;
                    n_result.hit_slot      = SLOT_W'(r_idx);
                    n_result.entry_address = r_addr[r_idx];
                    n_result.entry_session = r_sess[r_idx];
                    n_result.entry_device  = r_dev[r_idx];
                end
            end
            CMD_EXPIRE: begin
                n_result.removed_count = r_count;
            end
            CMD_CHECK_SEQ: begin
                n_result.duplicate = slot_ok && r_known[slot_idx] &&
                                     (r_seq[slot_idx] == r_item.seq_number);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Command register and pipeline payload.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_item <= load_item;
        end
        if (i_ctrl.match) begin
            for (int i = 0; i < NODES; i++) begin
                r_dev_hit[i]  <= r_valid[i] && (r_dev[i] == r_item.device_id);
                r_addr_hit[i] <= r_valid[i] && (r_addr[i] == r_item.node_address);
                r_free[i]     <= !r_valid[i];
                r_expired[i]  <= r_valid[i] && (r_item.now_ms >= r_dl[i]);
            end
            r_new_dl <= r_item.now_ms + r_timeout;
        end
        if (i_ctrl.select) begin
            r_count <= (n_expired > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(n_expired);
            case (r_item.cmd)
                CMD_REGISTER: begin
                    r_found <= (|r_dev_hit) || (|r_free);
                    r_idx   <= (|r_dev_hit) ? first_dev : first_free;
                end
                CMD_FIND_ADDR: begin
                    r_found <= |r_addr_hit;
                    r_idx   <= first_addr;
                end
                default: begin
                    r_found <= |r_dev_hit;
                    r_idx   <= first_dev;
                end
            endcase
        end
        if (i_ctrl.commit) begin
            r_result <= n_result;
        end
    end

    // Table write-back; every entry is updated independently at commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_valid[i] <= 1'b0;
                r_dev[i]   <= '0;
                r_addr[i]  <= '0;
                r_sess[i]  <= '0;
                r_dl[i]    <= '0;
                r_seq[i]   <= '0;
                r_known[i] <= 1'b0;
            end
        end else if (i_ctrl.commit) begin
            for (int i = 0; i < NODES; i++) begin
                case (r_item.cmd)
                    CMD_REGISTER: begin
                        if (r_found && (r_idx == IDX_W'(i))) begin
                            r_valid[i] <= 1'b1;
                            r_dev[i]   <= r_item.device_id;
                            r_addr[i]  <= r_item.node_address;
                            r_sess[i]  <= r_item.session;
                            r_dl[i]    <= r_new_dl;
                            r_seq[i]   <= '0;
                            r_known[i] <= 1'b0;
                        end
                    end
                    CMD_REMOVE, CMD_EXPIRE: begin
                        if ((r_item.cmd == CMD_EXPIRE) ? r_expired[i] :
                            (slot_ok && (slot_idx == IDX_W'(i)))) begin
                            r_valid[i] <= 1'b0;
                            r_dev[i]   <= '0;
                            r_addr[i]  <= '0;
                            r_sess[i]  <= '0;
                            r_dl[i]    <= '0;
                            r_seq[i]   <= '0;
                            r_known[i] <= 1'b0;
                        end
                    end
                    CMD_REFRESH: begin
                        if (slot_ok && (slot_idx == IDX_W'(i))) begin
                            r_dl[i] <= r_new_dl;
                        end
                    end
                    CMD_RECORD: begin
                        if (slot_ok && (slot_idx == IDX_W'(i))) begin
                            r_seq[i]   <= r_item.seq_number;
                            r_known[i] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_result = r_result;

endmodule

/* hw/rtl/node_table_keepalive_dedup.sv */
// Top level of the node table with keepalive expiry and duplicate detection.
//
// A command is taken when start is high and busy is low. Every command,
// whatever its kind, is loaded, has all entries compared in parallel, has
// the lowest matching or free slot picked, and has the table written back
// and the result registered. The result appears on o_result, where it is
// held, and o_done is high for exactly one cycle, in the same cycle that busy
// falls, so the next command may be started then. There is no flow control
// on the result side; the receiver must take each transfer as it comes. The
// timeout register may be written at any time the block is idle.
module node_table_keepalive_dedup #(
    parameter int NODES    = ntkd_pkg::NODES_DEF,
    parameter int ID_BYTES = ntkd_pkg::ID_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ntkd_pkg::t_item               i_item,
    input  logic                          i_cfg_we,
    input  logic [ntkd_pkg::TIME_W-1:0]   i_cfg_data,
    output logic                          o_done,
    output ntkd_pkg::t_result             o_result
);
    import ntkd_pkg::*;

    t_dp_ctrl ctrl;

    ntkd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_ctrl  (ctrl)
    );

    ntkd_dp #(
        .NODES    (NODES),
        .ID_BYTES (ID_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

endmodule
